// ===== hw/rtl/wrad_pkg.sv =====
// Shared constants and types for the window rate anomaly detector.
package wrad_pkg;

	localparam int WINDOW_DEF     = 20;
	localparam int COUNT_BITS_DEF = 16;
	localparam int IN_W           = 16;
	localparam int FIELD_W        = 5;
	localparam logic [FIELD_W-1:0] LIMIT_RESET = 5'd10;

	typedef struct packed {
		logic               closed;
		logic [FIELD_W-1:0] above;
		logic [FIELD_W-1:0] fill;
	} result_t;

endpackage

// ===== hw/rtl/wrad_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module wrad_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 20
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/wrad_core.sv =====
// Window update and above-mean scan, run by a small sequencer over the window RAM.
module wrad_core #(
	parameter int WINDOW     = wrad_pkg::WINDOW_DEF,
	parameter int COUNT_BITS = wrad_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [wrad_pkg::IN_W-1:0]           sample,
	input  logic [wrad_pkg::FIELD_W-1:0]        limit,
	output logic                                idle,
	output logic                                res_valid,
	input  logic                                res_ready,
	output wrad_pkg::result_t                   res
);
	import wrad_pkg::*;

	localparam int IDX_W  = $clog2(WINDOW);
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int SUM_W  = COUNT_BITS + FILL_W;
	localparam int CMP_W  = (FILL_W > FIELD_W) ? FILL_W : FIELD_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_OLD  = 3'd1;
	localparam logic [2:0] S_WR   = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]            state_q;
	logic [COUNT_BITS-1:0] sample_q;
	logic [SUM_W-1:0]      sum_q;
	logic [FILL_W-1:0]     fill_q;
	logic [IDX_W-1:0]      slot_q;
	logic [FILL_W-1:0]     idx_q;
	logic [FILL_W-1:0]     cnt_q;
	logic                  rd_pend_q;
	logic                  closed_q;

	logic                  ram_we;
	logic [IDX_W-1:0]      ram_raddr;
	logic [COUNT_BITS-1:0] ram_rdata;
	logic [SUM_W-1:0]      prod;
	logic                  above_now;
	logic                  closing;
	logic                  full;

	assign full      = (fill_q == FILL_W'(WINDOW));
	assign ram_we    = (state_q == S_WR);
	// In idle the oldest slot is read so that a full window can drop it next.
	assign ram_raddr = (state_q == S_IDLE) ? slot_q : idx_q[IDX_W-1:0];

	wrad_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(WINDOW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(slot_q),
		.wdata(sample_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Exact mean test: entry * fill > sum.
	assign prod      = {{FILL_W{1'b0}}, ram_rdata} * {{COUNT_BITS{1'b0}}, fill_q};
	assign above_now = rd_pend_q && (prod > sum_q);
	assign closing   = (CMP_W'(cnt_q) > CMP_W'(limit));

	assign idle       = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign res.closed = closed_q | closing;
	assign res.above  = FIELD_W'(cnt_q);
	assign res.fill   = FIELD_W'(fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sum_q     <= '0;
			fill_q    <= '0;
			slot_q    <= '0;
			idx_q     <= '0;
			cnt_q     <= '0;
			rd_pend_q <= 1'b0;
			closed_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cnt_q     <= '0;
						idx_q     <= '0;
						rd_pend_q <= 1'b0;
						if (closed_q) begin
							state_q <= S_DONE;
						end else if (full) begin
							state_q <= S_OLD;
						end else begin
							state_q <= S_WR;
						end
					end
				end
				S_OLD: begin
					sum_q   <= sum_q - SUM_W'(ram_rdata);
					state_q <= S_WR;
				end
				S_WR: begin
					sum_q <= sum_q + SUM_W'(sample_q);
					if (!full) begin
						fill_q <= fill_q + 1'b1;
					end
					slot_q  <= (slot_q == IDX_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					rd_pend_q <= (idx_q < fill_q);
					if (idx_q < fill_q) begin
						idx_q <= idx_q + 1'b1;
					end
					if (above_now) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (idx_q == fill_q && !rd_pend_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						closed_q <= closed_q | closing;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			sample_q <= COUNT_BITS'(sample);
		end
	end

endmodule

// ===== hw/rtl/window_rate_anomaly_detector_top.sv =====
// An accepted item steps through the core states old (only once the window is full), write,
// scan and done, then its result is registered in the output register; once closed, it goes
// straight to done. One item at a time: the scan reads one window entry per cycle from the
// single read port of the window RAM, and no new item is accepted until the core is idle again.
// Reset clears the window fill, sum, write slot and closure latch and sets the limit to 10.
// The window RAM needs no clearing pass: only written entries ever affect a result.
module window_rate_anomaly_detector_top #(
	parameter int WINDOW     = wrad_pkg::WINDOW_DEF,
	parameter int COUNT_BITS = wrad_pkg::COUNT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [wrad_pkg::IN_W-1:0]    packet_count,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         conn_closed,
	output logic [wrad_pkg::FIELD_W-1:0] above_mean_count,
	output logic [wrad_pkg::FIELD_W-1:0] window_fill,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [wrad_pkg::FIELD_W-1:0] cfg_data
);
	import wrad_pkg::*;

	logic [FIELD_W-1:0] above_limit_q;
	logic               core_idle;
	logic               res_valid;
	logic               res_ready;
	result_t            res;
	logic               out_valid_q;
	result_t            out_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = core_idle;
	// The output register frees up in the same cycle its result is taken.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			above_limit_q <= cfg_data;
		end
	end

	wrad_core #(
		.WINDOW    (WINDOW),
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_valid && in_ready),
		.sample   (packet_count),
		.limit    (above_limit_q),
		.idle     (core_idle),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign conn_closed      = out_q.closed;
	assign above_mean_count = out_q.above;
	assign window_fill      = out_q.fill;

endmodule
